FILE: src/sqd_pkg.sv
// Shared types, constants and helpers for the shortest-queue dispatcher.
// Used by sqd_alu and shortest_queue_dispatch_serve; no dependencies.
`timescale 1ns / 1ps

package sqd_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_NUM_QUEUES  = 3;
  localparam logic [7:0] QUANTUM_RESET = 8'd3;

  localparam int ALU_W = 8;
  localparam int ID_W  = 16;
  localparam int WORK_W = 8;

  localparam logic FUNC_ARRIVE = 1'b0;
  localparam logic FUNC_SERVE  = 1'b1;

  // Result of the shared compare/subtract unit.
  typedef struct packed {
    logic             lt;
    logic             eq;
    logic [ALU_W-1:0] diff;
  } alu_res_t;

  // tie % n by repeated compare-subtract on a 3-bit value (n >= 2).
  function automatic logic [2:0] tie_mod(input logic [2:0] tie, input int n);
    logic [2:0] r;
    r = tie;
    for (int i = 0; i < 7; i++) begin
      if (int'(r) >= n) begin
        r = r - 3'(n);
      end
    end
    return r;
  endfunction

endpackage

FILE: src/shortest_queue_dispatch_serve.sv
// Join-shortest-queue dispatcher with quantum service, top level.
// Depends on sqd_pkg and sqd_alu.
`timescale 1ns / 1ps

// Keeps NUM_QUEUES circular job FIFOs of QUEUE_DEPTH entries each, held in one
// shared job memory (id + remaining work). An arrive (func 0) places the job in
// the least-occupied queue (lowest index on ties, tie_pick mod NUM_QUEUES when
// all counts match) and returns one result; when every queue is full the job is
// dropped and a result with rejected set reports queue 0. A serve tick (func 1)
// removes service_quantum work from every queue head in index order, popping a
// head whose work is at or below the quantum, and returns one result per queue,
// last set on the final one. After the input transfer, an arrive scans the
// queue occupancies, then reads and executes on the chosen queue; a serve
// tick reads and then executes each queue in turn, and an execute step waits
// while the result side stalls. The scan and the serve pass visit one queue
// at a time through the single compare/subtract unit, and the job memory has
// one read port with registered read data (read step, then execute step, per
// queue). A finished result sits in the output register, so the next input
// transfer can be taken while it waits. The quantum register may be written
// only while the block is idle; it resets to 3.

module shortest_queue_dispatch_serve import sqd_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int NUM_QUEUES  = DEF_NUM_QUEUES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_data_i,
  // input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              func_i,
  input  logic [ID_W-1:0]   job_id_i,
  input  logic [WORK_W-1:0] work_units_i,
  input  logic [2:0]        tie_pick_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        queue_index_o,
  output logic              rejected_o,
  output logic [ID_W-1:0]   head_id_o,
  output logic [WORK_W-1:0] head_work_o,
  output logic [4:0]        occupancy_o,
  output logic              last_o
);

  localparam int QW      = $clog2(NUM_QUEUES);
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOTS   = NUM_QUEUES * QUEUE_DEPTH;
  localparam int ADDR_W  = $clog2(SLOTS);
  localparam int ENTRY_W = ID_W + WORK_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_READ = 4'b0100,
    ST_EXEC = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // config
  logic [7:0] quantum_q;

  // latched input item
  logic              func_q;
  logic [ID_W-1:0]   job_id_q;
  logic [WORK_W-1:0] work_q;
  logic [2:0]        tie_q;

  // queue bookkeeping
  logic [PTR_W-1:0] head_q  [NUM_QUEUES];
  logic [PTR_W-1:0] tail_q  [NUM_QUEUES];
  logic [CNT_W-1:0] count_q [NUM_QUEUES];

  // sequencer state
  logic [QW-1:0]    cur_q, cur_d;
  logic [QW-1:0]    best_q, best_d;
  logic [CNT_W-1:0] best_cnt_q, best_cnt_d;
  logic             full_q, full_d;
  logic             eq_q, eq_d;
  logic             fwd_q, fwd_d;

  // job memory
  logic [ENTRY_W-1:0] mem_q [SLOTS];
  logic [ENTRY_W-1:0] rd_data_q;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  head_addr, tail_addr, mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [2:0]        qidx_q, qidx_d;
  logic              rej_q, rej_d;
  logic [ID_W-1:0]   hid_q, hid_d;
  logic [WORK_W-1:0] hwork_q, hwork_d;
  logic [4:0]        occ_q, occ_d;
  logic              last_q, last_d;
  logic              out_load;

  // shared unit
  logic [ALU_W-1:0] alu_a, alu_b;
  alu_res_t         alu_res;

  // current queue view
  logic [CNT_W-1:0]  cnt_cur;
  logic [ID_W-1:0]   rd_id;
  logic [WORK_W-1:0] rd_work;
  logic              in_xfer, can_emit, last_queue;
  logic              head_inc, tail_inc, cnt_inc, cnt_dec;

  sqd_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign can_emit   = !out_valid_q || !out_stall_i;
  assign cnt_cur    = count_q[cur_q];
  assign last_queue = (cur_q == QW'(NUM_QUEUES - 1));
  assign rd_id      = rd_data_q[ENTRY_W-1:WORK_W];
  assign rd_work    = rd_data_q[WORK_W-1:0];

  // slot = queue * depth + pointer
  assign head_addr = ADDR_W'(cur_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_q[cur_q]);
  assign tail_addr = ADDR_W'(cur_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_q[cur_q]);

  // shared unit: occupancy compare during scan, work vs quantum on serve
  always_comb begin
    if (state_q == ST_SCAN) begin
      alu_a = ALU_W'(cnt_cur);
      alu_b = ALU_W'(best_cnt_q);
    end else begin
      alu_a = ALU_W'(rd_work);
      alu_b = ALU_W'(quantum_q);
    end
  end

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    best_d      = best_q;
    best_cnt_d  = best_cnt_q;
    full_d      = full_q;
    eq_d        = eq_q;
    fwd_d       = fwd_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = head_addr;
    mem_wdata   = {job_id_q, work_q};
    head_inc    = 1'b0;
    tail_inc    = 1'b0;
    cnt_inc     = 1'b0;
    cnt_dec     = 1'b0;
    out_load    = 1'b0;
    qidx_d      = 3'(cur_q);
    rej_d       = 1'b0;
    hid_d       = '0;
    hwork_d     = '0;
    occ_d       = 5'(cnt_cur);
    last_d      = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          best_d     = '0;
          best_cnt_d = count_q[0];
          full_d     = (count_q[0] == CNT_W'(QUEUE_DEPTH));
          eq_d       = 1'b1;
          if (func_i == FUNC_SERVE) begin
            cur_d   = '0;
            state_d = ST_READ;
          end else begin
            cur_d   = QW'(1);
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        full_d = full_q && (cnt_cur == CNT_W'(QUEUE_DEPTH));
        eq_d   = eq_q && (cnt_cur == count_q[0]);
        if (alu_res.lt) begin
          best_d     = cur_q;
          best_cnt_d = cnt_cur;
        end
        if (last_queue) begin
          if (full_d) begin
            cur_d = '0;
          end else if (eq_d) begin
            cur_d = QW'(tie_mod(tie_q, NUM_QUEUES));
          end else begin
            cur_d = best_d;
          end
          state_d = ST_READ;
        end else begin
          cur_d = cur_q + QW'(1);
        end
      end
      ST_READ: begin
        mem_re = 1'b1;
        fwd_d  = 1'b0;
        if (func_q == FUNC_ARRIVE && !full_q) begin
          // push; an empty queue's head is the job being written now
          mem_we    = 1'b1;
          mem_waddr = tail_addr;
          tail_inc  = 1'b1;
          cnt_inc   = 1'b1;
          fwd_d     = (cnt_cur == '0);
        end
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (can_emit) begin
          out_load = 1'b1;
          if (func_q == FUNC_ARRIVE) begin
            rej_d   = full_q;
            hid_d   = fwd_q ? job_id_q : rd_id;
            hwork_d = fwd_q ? work_q : rd_work;
            state_d = ST_IDLE;
          end else begin
            last_d = last_queue;
            if (cnt_cur != '0) begin
              if (alu_res.lt || alu_res.eq) begin
                head_inc = 1'b1;
                cnt_dec  = 1'b1;
                occ_d    = 5'(cnt_cur - CNT_W'(1));
              end else begin
                mem_we    = 1'b1;
                mem_wdata = {rd_id, alu_res.diff};
                hid_d     = rd_id;
                hwork_d   = alu_res.diff;
              end
            end
            if (last_queue) begin
              state_d = ST_IDLE;
            end else begin
              cur_d   = cur_q + QW'(1);
              state_d = ST_READ;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      quantum_q   <= QUANTUM_RESET;
      out_valid_q <= 1'b0;
      cur_q       <= '0;
      best_q      <= '0;
      best_cnt_q  <= '0;
      full_q      <= 1'b0;
      eq_q        <= 1'b0;
      fwd_q       <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cur_q       <= cur_d;
      best_q      <= best_d;
      best_cnt_q  <= best_cnt_d;
      full_q      <= full_d;
      eq_q        <= eq_d;
      fwd_q       <= fwd_d;
      if (cfg_we_i) begin
        quantum_q <= cfg_data_i;
      end
      if (head_inc) begin
        head_q[cur_q] <= ptr_next(head_q[cur_q]);
      end
      if (tail_inc) begin
        tail_q[cur_q] <= ptr_next(tail_q[cur_q]);
      end
      if (cnt_inc) begin
        count_q[cur_q] <= cnt_cur + CNT_W'(1);
      end else if (cnt_dec) begin
        count_q[cur_q] <= cnt_cur - CNT_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      func_q   <= func_i;
      job_id_q <= job_id_i;
      work_q   <= work_units_i;
      tie_q    <= tie_pick_i;
    end
    if (out_load) begin
      qidx_q  <= qidx_d;
      rej_q   <= rej_d;
      hid_q   <= hid_d;
      hwork_q <= hwork_d;
      occ_q   <= occ_d;
      last_q  <= last_d;
    end
  end

  // job memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[head_addr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign queue_index_o = qidx_q;
  assign rejected_o    = rej_q;
  assign head_id_o     = hid_q;
  assign head_work_o   = hwork_q;
  assign occupancy_o   = occ_q;
  assign last_o        = last_q;

  // ---- assertions ----

  // a taken input always starts a sequence
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q != ST_IDLE)
    else $error("block idle right after an input transfer");

  // a rejected result reports a full queue 0
  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rejected_o) |-> (occupancy_o == 5'(QUEUE_DEPTH) && queue_index_o == '0))
    else $error("rejected result without full queue 0");

  // the current queue never overflows
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_cur <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  // pointers and count agree for every queue
  for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_ptr_chk
    a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
      ((tail_q[g] >= head_q[g]) ? (CNT_W'(tail_q[g]) - CNT_W'(head_q[g]))
                                : (CNT_W'(tail_q[g]) + CNT_W'(QUEUE_DEPTH)
                                   - CNT_W'(head_q[g])))
      == ((count_q[g] == CNT_W'(QUEUE_DEPTH)) ? '0 : count_q[g]))
      else $error("head/tail pointers disagree with count");
  end

endmodule

FILE: src/sqd_alu.sv
// Shared compare/subtract unit of the dispatcher.
// Depends on sqd_pkg (alu_res_t, ALU_W).
`timescale 1ns / 1ps

module sqd_alu import sqd_pkg::*; (
  input  logic [ALU_W-1:0] a_i,
  input  logic [ALU_W-1:0] b_i,
  output alu_res_t         res_o
);

  always_comb begin
    res_o.lt   = (a_i < b_i);
    res_o.eq   = (a_i == b_i);
    res_o.diff = a_i - b_i;
  end

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for shortest_queue_dispatch_serve.
// Runs a directed table and random phases against a built-in dispatch predictor.
// Depends on sqd_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_top;
  import sqd_pkg::*;

  localparam int NQ = DEF_NUM_QUEUES;
  localparam int QD = DEF_QUEUE_DEPTH;
  // Worst block latency per item (serve pass) plus some margin.
  localparam int SETTLE_CYCLES = 2 * NQ + 4;

  // One input item as it goes over the input channel.
  typedef struct {
    logic              func;
    logic [ID_W-1:0]   job_id;
    logic [WORK_W-1:0] work;
    logic [2:0]        tie;
  } job_item_t;

  // One result item as it comes off the result channel.
  typedef struct packed {
    logic [2:0]        queue_index;
    logic              rejected;
    logic [ID_W-1:0]   head_id;
    logic [WORK_W-1:0] head_work;
    logic [4:0]        occupancy;
    logic              last;
  } queue_report_t;

  // Directed stimulus row. A row with reps > 1 is sent that many times with
  // the job id counting up. A typed row carries its report spelled out.
  typedef struct {
    logic              func;
    logic [ID_W-1:0]   job_id;
    logic [WORK_W-1:0] work;
    logic [2:0]        tie;
    int                reps;
    bit                typed;
    queue_report_t     report;
  } stim_row_t;

  localparam int NUM_ROWS = 14;
  localparam queue_report_t NO_REPORT = '0;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [7:0]        cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              func_i;
  logic [ID_W-1:0]   job_id_i;
  logic [WORK_W-1:0] work_units_i;
  logic [2:0]        tie_pick_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [2:0]        queue_index_o;
  logic              rejected_o;
  logic [ID_W-1:0]   head_id_o;
  logic [WORK_W-1:0] head_work_o;
  logic [4:0]        occupancy_o;
  logic              last_o;

  shortest_queue_dispatch_serve #(
    .QUEUE_DEPTH (QD),
    .NUM_QUEUES  (NQ)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .job_id_i      (job_id_i),
    .work_units_i  (work_units_i),
    .tie_pick_i    (tie_pick_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .queue_index_o (queue_index_o),
    .rejected_o    (rejected_o),
    .head_id_o     (head_id_o),
    .head_work_o   (head_work_o),
    .occupancy_o   (occupancy_o),
    .last_o        (last_o)
  );

  // ---------------------------------------------------------------------------
  // Clock, idling knobs, bookkeeping
  // ---------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  int gap_pct   = 0;   // chance per cycle that the sender holds off
  int stall_pct = 0;   // chance per cycle that the receiver stalls
  int mismatch_count = 0;

  queue_report_t awaited_reports[$];

  // ---------------------------------------------------------------------------
  // Dispatcher predictor: own copy of the job store, pointers and quantum
  // ---------------------------------------------------------------------------
  logic [ID_W-1:0]   job_ids_m  [NQ*QD];
  logic [WORK_W-1:0] job_work_m [NQ*QD];
  int                q_head  [NQ];
  int                q_tail  [NQ];
  int                q_count [NQ];
  logic [7:0]        quantum_m;

  // Report of queue q's current head as an arrive sees it (always last).
  function automatic queue_report_t head_report(input int q, input logic rej);
    queue_report_t rep;
    rep = '0;
    rep.queue_index = 3'(q);
    rep.rejected    = rej;
    rep.occupancy   = 5'(q_count[q]);
    rep.last        = 1'b1;
    if (q_count[q] != 0) begin
      rep.head_id   = job_ids_m[q*QD + q_head[q]];
      rep.head_work = job_work_m[q*QD + q_head[q]];
    end
    return rep;
  endfunction

  // Advance the predictor by one accepted item and queue up its reports.
  // A typed row replaces the arrive report by the one written in the table.
  task automatic predict_dispatch(input job_item_t it, input bit typed,
                                  input queue_report_t typed_rep);
    bit all_full;
    bit all_eq;
    int best;
    int s;
    queue_report_t rep;
    if (it.func == FUNC_ARRIVE) begin
      all_full = 1'b1;
      all_eq   = 1'b1;
      best     = 0;
      for (int q = 0; q < NQ; q++) begin
        if (q_count[q] < QD) all_full = 1'b0;
        if (q_count[q] != q_count[0]) all_eq = 1'b0;
        if (q_count[q] < q_count[best]) best = q;
      end
      if (all_full) begin
        // dropped job: report queue 0 unchanged
        rep = head_report(0, 1'b1);
      end else begin
        if (all_eq) best = int'(it.tie) % NQ;
        s = best * QD + q_tail[best];
        job_ids_m[s]  = it.job_id;
        job_work_m[s] = it.work;
        q_tail[best]  = (q_tail[best] + 1) % QD;
        q_count[best]++;
        rep = head_report(best, 1'b0);
      end
      awaited_reports.push_back(typed ? typed_rep : rep);
    end else begin
      for (int q = 0; q < NQ; q++) begin
        rep = '0;
        rep.queue_index = 3'(q);
        rep.last        = (q == NQ - 1);
        if (q_count[q] != 0) begin
          s = q * QD + q_head[q];
          if (job_work_m[s] <= quantum_m) begin
            // popped head: ids stay zero, next job not shown
            q_head[q] = (q_head[q] + 1) % QD;
            q_count[q]--;
          end else begin
            job_work_m[s]  = job_work_m[s] - quantum_m;
            rep.head_id    = job_ids_m[s];
            rep.head_work  = job_work_m[s];
          end
          rep.occupancy = 5'(q_count[q]);
        end
        awaited_reports.push_back(rep);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall, and check of every result transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    queue_report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_reports.size() == 0) begin
        $error("result transfer with nothing awaited (queue %0d)", queue_index_o);
        mismatch_count++;
      end else begin
        want = awaited_reports.pop_front();
        check_field("queue_index", 16'(want.queue_index), 16'(queue_index_o));
        check_field("rejected",    16'(want.rejected),    16'(rejected_o));
        check_field("head_id",     want.head_id,          head_id_o);
        check_field("head_work",   16'(want.head_work),   16'(head_work_o));
        check_field("occupancy",   16'(want.occupancy),   16'(occupancy_o));
        check_field("last",        16'(want.last),        16'(last_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Offer one item, hold it through stalls, predict once it transfers.
  task automatic send_item(input job_item_t it, input bit typed,
                           input queue_report_t typed_rep);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= it.func;
    job_id_i     <= it.job_id;
    work_units_i <= it.work;
    tie_pick_i   <= it.tie;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_dispatch(it, typed, typed_rep);
  endtask

  // Hold off until every awaited report has come, then settle if asked.
  task automatic wait_drained(input int settle);
    in_valid_i <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Quantum write, only with the block idle.
  task automatic set_quantum(input logic [7:0] value);
    wait_drained(SETTLE_CYCLES);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    quantum_m   = value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic job_item_t random_item(input int arrive_pct);
    job_item_t it;
    it.func   = ($urandom_range(0, 99) < arrive_pct) ? FUNC_ARRIVE : FUNC_SERVE;
    it.job_id = 16'($urandom_range(0, 65535));
    // mostly short jobs so queues drain, some full-range work, zero included
    it.work   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 6));
    it.tie    = 3'($urandom_range(0, 7));
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  stim_row_t dir_rows [NUM_ROWS];

  initial begin
    dir_rows = '{
      // serve with every queue empty
      '{FUNC_SERVE,  16'h0000, 8'h00, 3'd0, 1,  1'b0, NO_REPORT},
      // all counts equal: tie pick 7 wraps to queue 1, extreme id and work
      '{FUNC_ARRIVE, 16'hFFFF, 8'hFF, 3'd7, 1,  1'b1,
        '{3'd1, 1'b0, 16'hFFFF, 8'hFF, 5'd1, 1'b1}},
      // shortest queue is 0, tie pick ignored
      '{FUNC_ARRIVE, 16'h0001, 8'h01, 3'd0, 1,  1'b1,
        '{3'd0, 1'b0, 16'h0001, 8'h01, 5'd1, 1'b1}},
      // zero work job lands in queue 2
      '{FUNC_ARRIVE, 16'h8000, 8'h00, 3'd5, 1,  1'b1,
        '{3'd2, 1'b0, 16'h8000, 8'h00, 5'd1, 1'b1}},
      // all equal again, tie pick 6 wraps to 0; head still job 1
      '{FUNC_ARRIVE, 16'h1234, 8'h03, 3'd6, 1,  1'b1,
        '{3'd0, 1'b0, 16'h0001, 8'h01, 5'd2, 1'b1}},
      // pops below quantum and zero work, reduces the big job
      '{FUNC_SERVE,  16'h0000, 8'h00, 3'd0, 1,  1'b0, NO_REPORT},
      // work equal to quantum pops; queue 2 empty
      '{FUNC_SERVE,  16'h0000, 8'h00, 3'd0, 1,  1'b0, NO_REPORT},
      '{FUNC_ARRIVE, 16'h00AA, 8'h04, 3'd3, 1,  1'b0, NO_REPORT},
      '{FUNC_ARRIVE, 16'h5555, 8'h80, 3'd4, 1,  1'b0, NO_REPORT},
      // serve with ignored fields at their maximum
      '{FUNC_SERVE,  16'hFFFF, 8'hFF, 3'd7, 1,  1'b0, NO_REPORT},
      // fill every queue to full, the last few arrivals are dropped
      '{FUNC_ARRIVE, 16'h0100, 8'h02, 3'd2, 50, 1'b0, NO_REPORT},
      '{FUNC_SERVE,  16'h0000, 8'h00, 3'd0, 1,  1'b0, NO_REPORT},
      // one slot freed: first arrival fits, second is dropped
      '{FUNC_ARRIVE, 16'h0200, 8'h01, 3'd1, 2,  1'b0, NO_REPORT},
      // drain queue 0, wrapping its circular pointers; queues 1 and 2 keep their big heads
      '{FUNC_SERVE,  16'h0000, 8'h00, 3'd0, 20, 1'b0, NO_REPORT}
    };
  end

  // ---------------------------------------------------------------------------
  // Run
  // ---------------------------------------------------------------------------
  // Random phases: quantum, idling and arrive mix each phase uses.
  localparam int NUM_PHASES = 6;
  localparam int PHASE_ITEMS = 11;

  initial begin
    job_item_t   it;
    logic [7:0]  phase_quantum [NUM_PHASES];
    int          phase_arrive  [NUM_PHASES];
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_data_i   <= 8'h00;
    in_valid_i   <= 1'b0;
    func_i       <= FUNC_ARRIVE;
    job_id_i     <= '0;
    work_units_i <= '0;
    tie_pick_i   <= '0;
    for (int i = 0; i < NQ * QD; i++) begin
      job_ids_m[i]  = '0;
      job_work_m[i] = '0;
    end
    for (int q = 0; q < NQ; q++) begin
      q_head[q]  = 0;
      q_tail[q]  = 0;
      q_count[q] = 0;
    end
    quantum_m = QUANTUM_RESET;

    // quantum 1, max, zero (nonzero heads never shrink), then mixed values
    phase_quantum = '{8'd1, 8'd255, 8'd0, 8'($urandom_range(4, 254)), 8'd2,
                      8'($urandom_range(1, 255))};
    phase_arrive  = '{70, 40, 60, 75, 50, 65};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset quantum; sender rarely idles, receiver often
    gap_pct   = 7;
    stall_pct = 71;
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int k = 0; k < dir_rows[r].reps; k++) begin
        it.func   = dir_rows[r].func;
        it.job_id = dir_rows[r].job_id + 16'(k);
        it.work   = dir_rows[r].work;
        it.tie    = dir_rows[r].tie;
        send_item(it, dir_rows[r].typed, dir_rows[r].report);
      end
    end

    // random phases: idling swaps sides after two phases, then goes away
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 2) begin
        gap_pct   = 71;
        stall_pct = 7;
      end else if (p == 4) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      set_quantum(phase_quantum[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // mid-phase hold-off until everything in flight has come back
        if (i == PHASE_ITEMS / 2) wait_drained(0);
        send_item(random_item(phase_arrive[p]), 1'b0, NO_REPORT);
      end
    end

    wait_drained(SETTLE_CYCLES);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: filelist.f
src/sqd_pkg.sv
src/sqd_alu.sv
src/shortest_queue_dispatch_serve.sv
tb/tb_top.sv
